@@ rtl/frfa_pkg.sv @@
// Shared types and constants of the free run frame allocator.
package frfa_pkg;

  localparam int CMD_W   = 2;
  localparam int COUNT_W = 13;
  localparam int ALIGN_W = 4;
  localparam int INDEX_W = 12;
  localparam int STAT_W  = 3;
  localparam int FIRST_W = 12;
  localparam int QUOTA_W = 13;
  localparam int BASE_W  = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [QUOTA_W-1:0] QUOTA_RESET = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_ANY = 2'd0,
    CMD_ALLOC_AT  = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_QUOTA    = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_ALIGN    = 3'd4,
    ST_RANGE    = 3'd5,
    ST_PARTIAL  = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUOTA = 1'b0,
    CFG_BASE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_ADD1 = 2'd1,
    ALU_SUB  = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] frame_count;
    logic [ALIGN_W-1:0] align_log2;
    logic [INDEX_W-1:0] frame_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FIRST_W-1:0] first_frame;
    logic [COUNT_W-1:0] granted_count;
  } res_t;

  typedef struct packed {
    logic [QUOTA_W-1:0] quota;
    logic [BASE_W-1:0]  base;
  } cfg_regs_t;

endpackage

@@ rtl/frfa_if.sv @@
// Channel interfaces of the frame allocator: request, result and configuration write.
interface frfa_in_if import frfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COUNT_W-1:0] frame_count;
  logic [ALIGN_W-1:0] align_log2;
  logic [INDEX_W-1:0] frame_index;

  modport source (output valid, cmd, frame_count, align_log2, frame_index, input ready);
  modport sink   (input valid, cmd, frame_count, align_log2, frame_index, output ready);
endinterface

interface frfa_out_if import frfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [FIRST_W-1:0] first_frame;
  logic [COUNT_W-1:0] granted_count;

  modport source (output valid, status, first_frame, granted_count, input ready);
  modport sink   (input valid, status, first_frame, granted_count, output ready);
endinterface

interface frfa_cfg_if import frfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BASE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/frfa_alu.sv @@
// Shared adder and subtractor used by the steps of the allocator sequencer.
module frfa_alu import frfa_pkg::*; #(
  parameter int W = 15
) (
  input  alu_op_e      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y,
  output logic         carry
);

  logic [W:0] full;

  always_comb begin
    unique case (op)
      ALU_ADD:  full = {1'b0, a} + {1'b0, b};
      ALU_ADD1: full = {1'b0, a} + {1'b0, b} + (W+1)'(1);
      ALU_SUB:  full = {1'b0, a} + {1'b0, ~b} + (W+1)'(1);
      default:  full = '0;
    endcase
  end

  // For a subtraction the carry out is set exactly when a >= b.
  assign y     = full[W-1:0];
  assign carry = full[W];

endmodule

@@ rtl/frfa_table.sv @@
// Free run table: one write port and one registered read port.
module frfa_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/frfa_seq.sv @@
// Sequencer of the allocator: walks the free run table through the shared adder.
module frfa_seq import frfa_pkg::*; #(
  parameter int FRAMES         = 4096,
  parameter int MAX_ALIGN_LOG2 = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_t      req,
  input  logic      res_ready,
  output logic      res_valid,
  output res_t      res
);

  localparam int IW  = $clog2(FRAMES);
  localparam int TW  = $clog2(FRAMES + 1);
  localparam int MW  = MAX_ALIGN_LOG2 + 1;
  localparam int NW  = ((MAX_ALIGN_LOG2 > COUNT_W) ? MAX_ALIGN_LOG2 : COUNT_W) + 1;
  localparam int PW  = ((IW > MAX_ALIGN_LOG2) ? IW : MAX_ALIGN_LOG2) + 1;
  localparam int DW0 = (NW > PW) ? NW : PW;
  localparam int DW  = ((DW0 > TW) ? DW0 : TW) + 1;

  typedef enum logic [21:0] {
    S_CLEAR  = 22'h000001,
    S_IDLE   = 22'h000002,
    S_DECODE = 22'h000004,
    S_NEED   = 22'h000008,
    S_QSUM   = 22'h000010,
    S_QCMP   = 22'h000020,
    S_ALIGN  = 22'h000040,
    S_ABND   = 22'h000080,
    S_AGOT   = 22'h000100,
    S_SRD    = 22'h000200,
    S_SCMP   = 22'h000400,
    S_SSTEP  = 22'h000800,
    S_BKRD   = 22'h001000,
    S_BKCHK  = 22'h002000,
    S_ZERO   = 22'h004000,
    S_AFIN   = 22'h008000,
    S_FEND   = 22'h010000,
    S_FBND   = 22'h020000,
    S_FRUN   = 22'h040000,
    S_FFILL  = 22'h080000,
    S_FFIN   = 22'h100000,
    S_RESP   = 22'h200000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_e               cmd_r, cmd_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0]      mask_r, mask_nxt;
  logic [NW-1:0]      need_r, need_nxt;
  logic [DW-1:0]      sum_r, sum_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic [TW-1:0]      run_r, run_nxt;
  logic [IW-1:0]      first_r, first_nxt;
  logic [NW-1:0]      got_r, got_nxt;
  logic [NW-1:0]      zcnt_r, zcnt_nxt;
  logic               misal_r, misal_nxt;
  logic [MW-1:0]      off_r, off_nxt;
  logic               short_r, short_nxt;
  logic               end_eq_r, end_eq_nxt;
  status_e            st_r, st_nxt;
  res_t               res_r, res_nxt;
  logic [COUNT_W-1:0] alloc_r, alloc_nxt;

  logic [4:0]    a_in, a_sel;
  logic [PW-1:0] ptr_dec, ptr_dec2, ptr_inc;
  logic          walk_end;
  logic          is_free;

  alu_op_e       alu_op;
  logic [DW-1:0] alu_a, alu_b, alu_y;
  logic          alu_c;

  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [TW-1:0] wr_data, rd_data;

  frfa_alu #(.W(DW)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .y     (alu_y),
    .carry (alu_c)
  );

  frfa_table #(.DEPTH(FRAMES), .AW(IW), .DW(TW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ptr_dec  = ptr_r - PW'(1);
  assign ptr_dec2 = ptr_r - PW'(2);
  assign ptr_inc  = ptr_r + PW'(1);
  assign is_free  = (cmd_r == CMD_FREE);

  assign a_in  = {1'b0, req.align_log2};
  assign a_sel = (a_in > 5'(MAX_ALIGN_LOG2)) ? 5'(MAX_ALIGN_LOG2) : a_in;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    mask_nxt   = mask_r;
    need_nxt   = need_r;
    sum_nxt    = sum_r;
    ptr_nxt    = ptr_r;
    run_nxt    = run_r;
    first_nxt  = first_r;
    got_nxt    = got_r;
    zcnt_nxt   = zcnt_r;
    misal_nxt  = misal_r;
    off_nxt    = off_r;
    short_nxt  = short_r;
    end_eq_nxt = end_eq_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    alloc_nxt  = alloc_r;
    walk_end   = 1'b0;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    wr_en      = 1'b0;
    wr_addr    = ptr_r[IW-1:0];
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = ptr_r[IW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // Reset sweep: entry j gets FRAMES - j.
        alu_op  = ALU_SUB;
        alu_a   = DW'(FRAMES);
        alu_b   = DW'(ptr_r);
        wr_en   = 1'b1;
        wr_data = TW'(alu_y);
        ptr_nxt = ptr_inc;
        if (ptr_r == PW'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd_nxt   = cmd_e'(req.cmd);
          cnt_nxt   = req.frame_count;
          idx_nxt   = req.frame_index;
          mask_nxt  = (MW'(1) << a_sel) - MW'(1);
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cmd_r == CMD_NONE || cnt_r == '0) begin
          res_nxt.status        = ST_ZERO;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else if (is_free) begin
          state_nxt = S_FEND;
        end else begin
          state_nxt = S_NEED;
        end
      end
      S_NEED: begin
        alu_op    = ALU_ADD;
        alu_a     = DW'(cnt_r);
        alu_b     = DW'(mask_r);
        need_nxt  = NW'(alu_y & ~DW'(mask_r));
        state_nxt = S_QSUM;
      end
      S_QSUM: begin
        alu_op    = ALU_ADD;
        alu_a     = DW'(alloc_r);
        alu_b     = DW'(need_r);
        sum_nxt   = alu_y;
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        alu_op = ALU_SUB;
        alu_a  = DW'(cfg.quota);
        alu_b  = sum_r;
        if (!alu_c) begin
          res_nxt.status        = ST_QUOTA;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else if (cmd_r == CMD_ALLOC_ANY) begin
          ptr_nxt   = '0;
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        // Only the low bits of base + index matter for the alignment test.
        alu_op = ALU_ADD;
        alu_a  = DW'(cfg.base[MW-1:0]);
        alu_b  = DW'(idx_r);
        if (|(alu_y[MW-1:0] & mask_r)) begin
          res_nxt.status        = ST_ALIGN;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else begin
          state_nxt = S_ABND;
        end
      end
      S_ABND: begin
        alu_op  = ALU_SUB;
        alu_a   = DW'(idx_r);
        alu_b   = DW'(FRAMES);
        rd_en   = !alu_c;
        rd_addr = IW'(idx_r);
        if (alu_c) begin
          res_nxt.status        = ST_RANGE;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else begin
          ptr_nxt   = PW'(idx_r);
          state_nxt = S_AGOT;
        end
      end
      S_AGOT: begin
        alu_op    = ALU_SUB;
        alu_a     = DW'(rd_data);
        alu_b     = DW'(need_r);
        run_nxt   = rd_data;
        first_nxt = IW'(idx_r);
        if (alu_c) begin
          got_nxt  = need_r;
          zcnt_nxt = need_r;
          st_nxt   = ST_OK;
        end else begin
          got_nxt  = NW'(rd_data);
          zcnt_nxt = NW'(rd_data);
          st_nxt   = ST_PARTIAL;
        end
        // A used frame grants nothing, so the table stays as it is.
        state_nxt = (rd_data == '0) ? S_AFIN : S_BKRD;
      end
      S_SRD: begin
        if (ptr_r >= PW'(FRAMES)) begin
          res_nxt.status        = ST_NOSPACE;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else begin
          rd_en     = 1'b1;
          alu_op    = ALU_ADD;
          alu_a     = DW'(cfg.base[MW-1:0]);
          alu_b     = DW'(ptr_r);
          misal_nxt = |(alu_y[MW-1:0] & mask_r);
          off_nxt   = ~alu_y[MW-1:0] & mask_r;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        alu_op = ALU_SUB;
        alu_a  = DW'(rd_data);
        alu_b  = DW'(need_r);
        if (rd_data == '0) begin
          state_nxt = S_SSTEP;
        end else if (!alu_c) begin
          short_nxt = 1'b1;
          state_nxt = S_SSTEP;
        end else if (misal_r) begin
          short_nxt = 1'b0;
          state_nxt = S_SSTEP;
        end else begin
          run_nxt   = rd_data;
          first_nxt = ptr_r[IW-1:0];
          got_nxt   = need_r;
          zcnt_nxt  = need_r;
          st_nxt    = ST_OK;
          state_nxt = S_BKRD;
        end
      end
      S_SSTEP: begin
        // A used frame steps by one, a run that is too short is skipped whole,
        // and a misaligned start jumps to the next aligned frame.
        alu_a = DW'(ptr_r);
        if (rd_data == '0) begin
          alu_op = ALU_ADD1;
          alu_b  = '0;
        end else if (short_r) begin
          alu_op = ALU_ADD;
          alu_b  = DW'(rd_data);
        end else begin
          alu_op = ALU_ADD1;
          alu_b  = DW'(off_r);
        end
        ptr_nxt   = PW'(alu_y);
        state_nxt = S_SRD;
      end
      S_BKRD: begin
        if (ptr_r == '0) begin
          walk_end = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec[IW-1:0];
          state_nxt = S_BKCHK;
        end
      end
      S_BKCHK: begin
        // Walk back over the free frames in front: one entry per cycle,
        // the next read overlapping the current write.
        if (rd_data == '0) begin
          walk_end = 1'b1;
        end else begin
          if (is_free) begin
            alu_op  = ALU_ADD1;
            alu_a   = DW'(run_r);
            alu_b   = '0;
            run_nxt = TW'(alu_y);
          end else begin
            alu_op = ALU_SUB;
            alu_a  = DW'(rd_data);
            alu_b  = DW'(run_r);
          end
          wr_en   = 1'b1;
          wr_addr = ptr_dec[IW-1:0];
          wr_data = TW'(alu_y);
          ptr_nxt = ptr_dec;
          if (ptr_dec == '0) begin
            walk_end = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[IW-1:0];
          end
        end
      end
      S_ZERO: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        ptr_nxt  = ptr_inc;
        zcnt_nxt = zcnt_r - NW'(1);
        if (zcnt_r == NW'(1)) begin
          state_nxt = S_AFIN;
        end
      end
      S_AFIN: begin
        alloc_nxt             = COUNT_W'(sum_r);
        res_nxt.status        = st_r;
        res_nxt.first_frame   = FIRST_W'(first_r);
        res_nxt.granted_count = COUNT_W'(got_r);
        state_nxt             = S_RESP;
      end
      S_FEND: begin
        alu_op    = ALU_ADD;
        alu_a     = DW'(idx_r);
        alu_b     = DW'(cnt_r);
        sum_nxt   = alu_y;
        state_nxt = S_FBND;
      end
      S_FBND: begin
        // The count is nonzero, so an end inside the region also bounds the start.
        alu_op  = ALU_SUB;
        alu_a   = DW'(FRAMES);
        alu_b   = sum_r;
        rd_en   = alu_c && (alu_y != '0);
        rd_addr = IW'(sum_r);
        if (!alu_c) begin
          res_nxt.status        = ST_RANGE;
          res_nxt.first_frame   = '0;
          res_nxt.granted_count = '0;
          state_nxt             = S_RESP;
        end else begin
          end_eq_nxt = (alu_y == '0);
          ptr_nxt    = PW'(sum_r);
          zcnt_nxt   = NW'(cnt_r);
          state_nxt  = S_FRUN;
        end
      end
      S_FRUN: begin
        run_nxt   = end_eq_r ? '0 : rd_data;
        state_nxt = S_FFILL;
      end
      S_FFILL: begin
        alu_op   = ALU_ADD1;
        alu_a    = DW'(run_r);
        alu_b    = '0;
        run_nxt  = TW'(alu_y);
        wr_en    = 1'b1;
        wr_addr  = ptr_dec[IW-1:0];
        wr_data  = TW'(alu_y);
        ptr_nxt  = ptr_dec;
        zcnt_nxt = zcnt_r - NW'(1);
        if (zcnt_r == NW'(1)) begin
          state_nxt = S_BKRD;
        end
      end
      S_FFIN: begin
        alu_op = ALU_SUB;
        alu_a  = DW'(alloc_r);
        alu_b  = DW'(cnt_r);
        if (alu_c) begin
          alloc_nxt      = COUNT_W'(alu_y);
          res_nxt.status = ST_OK;
        end else begin
          alloc_nxt      = '0;
          res_nxt.status = ST_PARTIAL;
        end
        res_nxt.first_frame   = idx_r;
        res_nxt.granted_count = cnt_r;
        state_nxt             = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (walk_end) begin
      if (is_free) begin
        state_nxt = S_FFIN;
      end else begin
        ptr_nxt   = PW'(first_r);
        state_nxt = S_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      alloc_r <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      alloc_r <= alloc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    mask_r   <= mask_nxt;
    need_r   <= need_nxt;
    sum_r    <= sum_nxt;
    run_r    <= run_nxt;
    first_r  <= first_nxt;
    got_r    <= got_nxt;
    zcnt_r   <= zcnt_nxt;
    misal_r  <= misal_nxt;
    off_r    <= off_nxt;
    short_r  <= short_nxt;
    end_eq_r <= end_eq_nxt;
    st_r     <= st_nxt;
    res_r    <= res_nxt;
  end

endmodule

@@ rtl/free_run_frame_allocator_unit.sv @@
// Top level of the free run frame allocator: configuration registers and result register.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    cmd, frame_count, align_log2, frame_index
//   out_ch    source     valid/ready    status, first_frame, granted_count
//   cfg_ch    sink       valid/ready    index, data (always ready)
//
// After reset the table is swept once, one entry per cycle, before the first request
// beat is taken; configuration writes are taken throughout.
// A request runs through its checks, then first-fit probes that read, compare and
// step (a probe lands on each used frame, run start or aligned candidate), a walk back
// over the table entries in front of the range, and a pass over each frame cleared or
// freed. The single table read port and the shared adder serialize these steps.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted.
module free_run_frame_allocator_unit import frfa_pkg::*; #(
  parameter int FRAMES         = 4096,
  parameter int MAX_ALIGN_LOG2 = 12
) (
  input logic        clk,
  input logic        rst_n,
  frfa_in_if.sink    in_ch,
  frfa_out_if.source out_ch,
  frfa_cfg_if.sink   cfg_ch
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  res_t      out_res_r, out_res_nxt;

  req_t req;
  res_t res;
  logic res_valid, res_ready;

  assign req.cmd         = in_ch.cmd;
  assign req.frame_count = in_ch.frame_count;
  assign req.align_log2  = in_ch.align_log2;
  assign req.frame_index = in_ch.frame_index;

  frfa_seq #(.FRAMES(FRAMES), .MAX_ALIGN_LOG2(MAX_ALIGN_LOG2)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_e'(cfg_ch.index))
        CFG_QUOTA: cfg_nxt.quota = cfg_ch.data[QUOTA_W-1:0];
        CFG_BASE:  cfg_nxt.base  = cfg_ch.data;
      endcase
    end
  end

  // The result register frees up in the same cycle its beat is taken.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quota <= QUOTA_RESET;
      cfg_r.base  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.first_frame   = out_res_r.first_frame;
  assign out_ch.granted_count = out_res_r.granted_count;

endmodule

@@ tb/free_run_frame_allocator_unit_tb.sv @@
// Self-checking testbench for the free run frame allocator with a mirrored frame table.
module free_run_frame_allocator_unit_tb;
  import frfa_pkg::*;

  localparam int FRAMES_N       = 4096;
  localparam int MAX_ALIGN      = 12;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES    = 32;

  // Mirror of the frame table, the held frame count and the two registers.
  class frame_allocator_mirror;
    int unsigned run_len [FRAMES_N];
    int unsigned held;
    int unsigned quota;
    int unsigned base;
    res_t        pending_grants [$];
    int          failures;
    int          reported;

    function new();
      for (int j = 0; j < FRAMES_N; j++) run_len[j] = FRAMES_N - j;
      held = 0;
      quota = 32'(QUOTA_RESET);
      base = 0;
      failures = 0;
      reported = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [BASE_W-1:0] data);
      if (idx == CFG_QUOTA) quota = 32'(data[QUOTA_W-1:0]);
      else base = 32'(data);
    endfunction

    function bit aligned(int unsigned f, int unsigned a);
      int unsigned mask;
      mask = (32'd1 << a) - 1;
      return ((base + f) & mask) == 0;
    endfunction

    function res_t make_res(status_e s, int unsigned f, int unsigned c);
      res_t r;
      r.status = s;
      r.first_frame = f[FIRST_W-1:0];
      r.granted_count = c[COUNT_W-1:0];
      return r;
    endfunction

    // Marks a range used and shortens the free run that ends right in front of it.
    function void claim(int unsigned first, int unsigned cnt);
      int unsigned run, i;
      run = run_len[first];
      i = first;
      while (i != 0) begin
        i--;
        if (run_len[i] == 0) break;
        run_len[i] -= run;
      end
      for (int unsigned j = first; j < first + cnt && j < FRAMES_N; j++) run_len[j] = 0;
    endfunction

    function res_t predict(req_t rq);
      int unsigned cnt, a, idx, need, stop_at, run, i, f, got;
      bit found;
      cnt = 32'(rq.frame_count);
      a = 32'(rq.align_log2);
      idx = 32'(rq.frame_index);
      if (rq.cmd == CMD_NONE || cnt == 0) return make_res(ST_ZERO, 0, 0);
      if (rq.cmd == CMD_FREE) begin
        stop_at = idx + cnt;
        if (idx >= FRAMES_N || stop_at > FRAMES_N) return make_res(ST_RANGE, 0, 0);
        run = (stop_at == FRAMES_N) ? 0 : run_len[stop_at];
        i = stop_at;
        while (i > idx) begin
          i--;
          run++;
          run_len[i] = run;
        end
        // Free frames just in front of the range join the new run.
        while (i != 0 && run_len[i-1] != 0) begin
          i--;
          run++;
          run_len[i] = run;
        end
        if (cnt > held) begin
          held = 0;
          return make_res(ST_PARTIAL, idx, cnt);
        end
        held -= cnt;
        return make_res(ST_OK, idx, cnt);
      end
      if (a > MAX_ALIGN) a = MAX_ALIGN;
      need = ((cnt + (32'd1 << a) - 1) >> a) << a;
      if (held + need > quota) return make_res(ST_QUOTA, 0, 0);
      if (rq.cmd == CMD_ALLOC_ANY) begin
        found = 1'b0;
        f = 0;
        for (int unsigned k = 0; k < FRAMES_N && !found; k++) begin
          if (run_len[k] >= need && aligned(k, a)) begin
            found = 1'b1;
            f = k;
          end
        end
        if (!found) return make_res(ST_NOSPACE, 0, 0);
        claim(f, need);
        held = (held + need) & 32'h1FFF;
        return make_res(ST_OK, f, need);
      end
      if (!aligned(idx, a)) return make_res(ST_ALIGN, 0, 0);
      // A short run is granted as far as it goes, but the full count is charged.
      got = (run_len[idx] < need) ? run_len[idx] : need;
      claim(idx, got);
      held = (held + need) & 32'h1FFF;
      return make_res((got < need) ? ST_PARTIAL : ST_OK, idx, got);
    endfunction

    function res_t note_request(req_t rq);
      res_t r;
      r = predict(rq);
      pending_grants.push_back(r);
      return r;
    endfunction

    function void check_grant(logic [STAT_W-1:0] st, logic [FIRST_W-1:0] ff,
                              logic [COUNT_W-1:0] gc);
      res_t want;
      if (pending_grants.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: st=%0d first=%0d count=%0d", st, ff, gc);
        end
        return;
      end
      want = pending_grants.pop_front();
      if (st !== want.status || ff !== want.first_frame || gc !== want.granted_count) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("result mismatch: expected st=%0d first=%0d count=%0d, got st=%0d first=%0d count=%0d",
                   want.status, want.first_frame, want.granted_count, st, ff, gc);
        end
      end
    endfunction

    function int pending_count();
      return pending_grants.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  frfa_in_if  in_ch ();
  frfa_out_if out_ch ();
  frfa_cfg_if cfg_ch ();

  free_run_frame_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_allocator_mirror mirror = new();

  int unsigned live_first [$];
  int unsigned live_cnt [$];
  int          live_frames = 0;
  int          calm_left = 0;
  int          idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.frame_count = '0;
    in_ch.align_log2 = '0;
    in_ch.frame_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0 || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(17, 128);
    if (r < 96) return $urandom_range(129, 1024);
    if (r < 99) return $urandom_range(1025, 4096);
    return $urandom_range(0, 8191);
  endfunction

  function automatic int unsigned pick_align();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(9, 15);
  endfunction

  function automatic req_t mk(cmd_e c, int unsigned cnt, int unsigned a, int unsigned idx);
    req_t rq;
    rq.cmd = c;
    rq.frame_count = cnt[COUNT_W-1:0];
    rq.align_log2 = a[ALIGN_W-1:0];
    rq.frame_index = idx[INDEX_W-1:0];
    return rq;
  endfunction

  // Mostly frees of blocks still held and allocations, with some noise beats.
  function automatic req_t random_req();
    req_t rq;
    int r, bias, k;
    int unsigned f, c;
    rq = mk(CMD_ALLOC_ANY, pick_count(), pick_align(), $urandom_range(0, FRAMES_N - 1));
    r = $urandom_range(0, 99);
    bias = (live_frames > 1800) ? 30 : 0;
    if (r < 5) begin
      rq.cmd = 2'($urandom_range(0, 3));
      rq.frame_count = ($urandom_range(0, 1) == 0) ? '0 : COUNT_W'($urandom_range(0, 8191));
    end else if (r < 45 - bias) begin
      rq.cmd = CMD_ALLOC_ANY;
    end else if (r < 60 - bias) begin
      rq.cmd = CMD_ALLOC_AT;
      if ($urandom_range(0, 9) < 7) rq.align_log2 = '0;
      if (live_first.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, live_first.size() - 1);
        f = ($urandom_range(0, 2) != 0) ? live_first[k] + live_cnt[k] : live_first[k];
        rq.frame_index = f[INDEX_W-1:0];
      end
    end else begin
      rq.cmd = CMD_FREE;
      if (live_first.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_first.size() - 1);
        f = live_first[k];
        c = live_cnt[k];
        live_first.delete(k);
        live_cnt.delete(k);
        live_frames -= c;
        if (c > 1 && $urandom_range(0, 7) == 0) begin
          live_first.push_back(f + c / 2);
          live_cnt.push_back(c - c / 2);
          live_frames += c - c / 2;
          c = c / 2;
        end
        rq.frame_index = f[INDEX_W-1:0];
        rq.frame_count = c[COUNT_W-1:0];
      end else if ($urandom_range(0, 19) == 0) begin
        rq.frame_index = '0;
        rq.frame_count = COUNT_W'(FRAMES_N);
      end
    end
    return rq;
  endfunction

  function automatic void track(req_t rq, res_t got);
    if ((rq.cmd == CMD_ALLOC_ANY || rq.cmd == CMD_ALLOC_AT) &&
        (got.status == ST_OK || got.status == ST_PARTIAL) && got.granted_count != 0) begin
      live_first.push_back(32'(got.first_frame));
      live_cnt.push_back(32'(got.granted_count));
      live_frames += 32'(got.granted_count);
    end
    if (rq.cmd == CMD_FREE && rq.frame_index == 0 && rq.frame_count == FRAMES_N) begin
      live_first.delete();
      live_cnt.delete();
      live_frames = 0;
    end
  endfunction

  task automatic send_req(req_t rq);
    int gap;
    res_t got;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd <= rq.cmd;
    in_ch.frame_count <= rq.frame_count;
    in_ch.align_log2 <= rq.align_log2;
    in_ch.frame_index <= rq.frame_index;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    got = mirror.note_request(rq);
    track(rq, got);
  endtask

  // Holds the request side until every outstanding result has been taken.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (mirror.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [BASE_W-1:0] data);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    mirror.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [BASE_W-1:0] quota_data, logic [BASE_W-1:0] base_data,
                           int n_items);
    settle();
    write_reg(CFG_QUOTA, quota_data);
    write_reg(CFG_BASE, base_data);
    for (int n = 0; n < n_items; n++) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(20, 60);
      if ($urandom_range(0, 199) == 0) settle();
      send_req(random_req());
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.check_grant(out_ch.status, out_ch.first_frame, out_ch.granted_count);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", mirror.pending_count());
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_QUOTA, BASE_W'(QUOTA_RESET));
    write_reg(CFG_BASE, '0);
    send_req(mk(CMD_ALLOC_ANY, 0, 0, 0));
    send_req(mk(CMD_NONE, 4096, 15, 4095));
    send_req(mk(CMD_ALLOC_ANY, 1, 0, 0));
    send_req(mk(CMD_ALLOC_ANY, 5, 2, 0));
    send_req(mk(CMD_ALLOC_AT, 1, 0, 3));
    send_req(mk(CMD_ALLOC_AT, 4, 2, 5));
    send_req(mk(CMD_ALLOC_AT, 2, 0, 4));
    // Tail of the region holds fewer frames than asked for.
    send_req(mk(CMD_ALLOC_AT, 8, 0, 4092));
    // An alignment above the maximum saturates and the rounded count breaks the quota.
    send_req(mk(CMD_ALLOC_ANY, 1, 15, 0));
    send_req(mk(CMD_ALLOC_ANY, 8191, 0, 0));
    send_req(mk(CMD_FREE, 0, 0, 7));
    send_req(mk(CMD_FREE, 10, 0, 4090));
    send_req(mk(CMD_FREE, 1, 0, 4095));
    send_req(mk(CMD_FREE, 4096, 0, 0));
    send_req(mk(CMD_ALLOC_AT, 4000, 0, 0));
    send_req(mk(CMD_ALLOC_ANY, 200, 0, 0));
    send_req(mk(CMD_ALLOC_ANY, 96, 5, 0));
    send_req(mk(CMD_FREE, 4096, 0, 0));
    send_req(mk(CMD_ALLOC_ANY, 4096, 12, 0));
    send_req(mk(CMD_ALLOC_ANY, 1, 0, 0));
    send_req(mk(CMD_FREE, 4096, 0, 0));
    send_req(mk(CMD_ALLOC_AT, 4096, 12, 0));
    send_req(mk(CMD_FREE, 4096, 0, 0));
    live_first.delete();
    live_cnt.delete();
    live_frames = 0;

    run_phase(BASE_W'(QUOTA_RESET), '0, 480);
    run_phase('0, 20'hFFFFF, 80);
    run_phase({7'($urandom_range(0, 127)), 13'h1FFF}, 20'($urandom_range(0, 20'hFFFFF)), 400);
    run_phase(20'($urandom_range(16, 600)), 20'($urandom_range(0, 15)), 350);
    run_phase(BASE_W'(QUOTA_RESET), '0, 420);
    settle();

    if (mirror.failures == 0 && mirror.pending_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
